[rtl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  // Field widths of the pixel channels
  localparam int FIELD_W = 16;
  localparam int CHAN_W  = 8;
  localparam int CHAN_MAX = 255;

  // Default number of fraction bits in the hue, saturation and value codes
  localparam int FRAC_BITS_DEF = 12;

  // Hue circle is cut into this many sectors
  localparam int HUE_SECTORS = 6;
  localparam int SECTOR_W = 3;

  // Hue sectors, named by the primary/secondary colors they span
  typedef enum logic [SECTOR_W-1:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  // Per-pixel control that rides along the pipeline
  typedef struct packed {
    logic                grey;
    sector_t             sector;
    logic [CHAN_W-1:0]   cv;
  } pix_ctl_t;

  // Largest saturation code that still counts as grey (below 0.003)
  function automatic int grey_max(input int frac_bits);
    int one;
    one = 1 << frac_bits;
    return (3 * one + 999) / 1000 - 1;
  endfunction

endpackage

[rtl/hsv2rgb_if.sv]
interface hsv2rgb_hsv_if;
  import hsv2rgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] hue;
  logic [FIELD_W-1:0] saturation;
  logic [FIELD_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_rgb_if;
  import hsv2rgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/hsv2rgb_front.sv]
module hsv2rgb_front #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsv2rgb_hsv_if.sink           in_px,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hsv2rgb_pkg::pix_ctl_t dn_ctl,
  output logic [FRAC_BITS:0]    dn_sat,
  output logic [FRAC_BITS:0]    dn_val,
  output logic [FRAC_BITS-1:0]  dn_frac
);
  import hsv2rgb_pkg::*;

  localparam int UNIT_W = FRAC_BITS + 1;
  localparam int EXT_W  = FIELD_W + 1;
  localparam int HUE6_W = FRAC_BITS + SECTOR_W;
  localparam int PROD_W = EXT_W + CHAN_W;
  localparam logic [EXT_W-1:0]   ONE_EXT  = EXT_W'(1) << FRAC_BITS;
  localparam logic [FIELD_W-1:0] GREY_MAX = FIELD_W'(grey_max(FRAC_BITS));

  logic [EXT_W-1:0]     sat_ext;
  logic [EXT_W-1:0]     val_ext;
  logic [EXT_W-1:0]     val_sel;
  logic [UNIT_W-1:0]    sat_wrap;
  logic [UNIT_W-1:0]    val_wrap;
  logic [HUE6_W-1:0]    hue6;
  logic [PROD_W-1:0]    val_prod;
  logic [PROD_W-1:0]    val_shift;
  logic                 grey;
  logic [CHAN_W-1:0]    cv;
  logic                 en;

  logic                 vld_r;
  pix_ctl_t             ctl_r;
  logic [UNIT_W-1:0]    sat_r;
  logic [UNIT_W-1:0]    val_r;
  logic [FRAC_BITS-1:0] frac_r;

  // Grey test on the raw saturation code
  assign grey = (in_px.saturation <= GREY_MAX);

  // Wrap saturation and value above one to their fraction
  assign sat_ext  = {1'b0, in_px.saturation};
  assign val_ext  = {1'b0, in_px.brightness};
  assign sat_wrap = (sat_ext > ONE_EXT) ? {1'b0, sat_ext[FRAC_BITS-1:0]}
                                        : sat_ext[FRAC_BITS:0];
  assign val_wrap = (val_ext > ONE_EXT) ? {1'b0, val_ext[FRAC_BITS-1:0]}
                                        : val_ext[FRAC_BITS:0];

  // Hue fraction times six: sector in the top bits, position below
  assign hue6 = HUE6_W'(in_px.hue[FRAC_BITS-1:0]) * HUE6_W'(HUE_SECTORS);

  // Value channel, saturated for the unwrapped grey case
  assign val_sel   = grey ? val_ext : EXT_W'(val_wrap);
  assign val_prod  = PROD_W'(val_sel) * PROD_W'(CHAN_MAX);
  assign val_shift = val_prod >> FRAC_BITS;
  assign cv = (val_shift > PROD_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX)
                                               : val_shift[CHAN_W-1:0];

  // Advance when empty or when the next stage takes the transaction
  assign en          = !vld_r || dn_ready;
  assign in_px.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_px.valid) begin
      ctl_r.grey   <= grey;
      ctl_r.sector <= sector_t'(hue6[HUE6_W-1 -: SECTOR_W]);
      ctl_r.cv     <= cv;
      sat_r        <= sat_wrap;
      val_r        <= val_wrap;
      frac_r       <= hue6[FRAC_BITS-1:0];
    end
  end

  assign dn_valid = vld_r;
  assign dn_ctl   = ctl_r;
  assign dn_sat   = sat_r;
  assign dn_val   = val_r;
  assign dn_frac  = frac_r;

endmodule

[rtl/hsv2rgb_mul.sv]
module hsv2rgb_mul #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  hsv2rgb_pkg::pix_ctl_t      up_ctl,
  input  logic [FRAC_BITS:0]         up_sat,
  input  logic [FRAC_BITS:0]         up_val,
  input  logic [FRAC_BITS-1:0]       up_frac,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output hsv2rgb_pkg::pix_ctl_t      dn_ctl,
  output logic [2*FRAC_BITS+9:0]     dn_p,
  output logic [2*FRAC_BITS+9:0]     dn_q_hi,
  output logic [2*FRAC_BITS+9:0]     dn_q_lo,
  output logic [2*FRAC_BITS+9:0]     dn_t_hi,
  output logic [2*FRAC_BITS+9:0]     dn_t_lo
);
  import hsv2rgb_pkg::*;

  localparam int UNIT_W = FRAC_BITS + 1;
  localparam int SQ_W   = 2 * FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + CHAN_W + 1;
  localparam int PROD_W = U_W + UNIT_W;
  localparam logic [UNIT_W-1:0] ONE_U  = UNIT_W'(1) << FRAC_BITS;
  localparam logic [SQ_W-1:0]   ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

  logic [UNIT_W-1:0] frac_w;
  logic [UNIT_W-1:0] pm;
  logic [SQ_W-1:0]   sf;
  logic [SQ_W-1:0]   sg;
  logic [U_W-1:0]    u;
  logic              en2;
  logic              en3;

  logic              vld2_r;
  pix_ctl_t          ctl2_r;
  logic [U_W-1:0]    u2_r;
  logic [UNIT_W-1:0] pm2_r;
  logic [SQ_W-1:0]   qx2_r;
  logic [SQ_W-1:0]   tx2_r;

  logic              vld3_r;
  pix_ctl_t          ctl3_r;
  logic [PROD_W-1:0] p3_r;
  logic [PROD_W-1:0] qhi3_r;
  logic [PROD_W-1:0] qlo3_r;
  logic [PROD_W-1:0] thi3_r;
  logic [PROD_W-1:0] tlo3_r;

  // Handshake: each stage moves when empty or when drained downstream
  assign en3      = !vld3_r || dn_ready;
  assign en2      = !vld2_r || en3;
  assign up_ready = en2;

  // Stage 2: saturation products and value times 255
  assign frac_w = UNIT_W'(up_frac);
  assign pm     = ONE_U - up_sat;
  assign sf     = SQ_W'(up_sat) * SQ_W'(frac_w);
  assign sg     = SQ_W'(up_sat) * SQ_W'(ONE_U - frac_w);
  assign u      = U_W'(up_val) * U_W'(CHAN_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en2) begin
      vld2_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && up_valid) begin
      ctl2_r <= up_ctl;
      u2_r   <= u;
      pm2_r  <= pm;
      qx2_r  <= ONE_SQ - sf;
      tx2_r  <= ONE_SQ - sg;
    end
  end

  // Stage 3: scaled value times the weights, wide weights split in halves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en3) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && vld2_r) begin
      ctl3_r <= ctl2_r;
      p3_r   <= PROD_W'(u2_r) * PROD_W'(pm2_r);
      qhi3_r <= PROD_W'(u2_r) * PROD_W'(qx2_r[SQ_W-1:FRAC_BITS]);
      qlo3_r <= PROD_W'(u2_r) * PROD_W'(qx2_r[FRAC_BITS-1:0]);
      thi3_r <= PROD_W'(u2_r) * PROD_W'(tx2_r[SQ_W-1:FRAC_BITS]);
      tlo3_r <= PROD_W'(u2_r) * PROD_W'(tx2_r[FRAC_BITS-1:0]);
    end
  end

  assign dn_valid = vld3_r;
  assign dn_ctl   = ctl3_r;
  assign dn_p     = p3_r;
  assign dn_q_hi  = qhi3_r;
  assign dn_q_lo  = qlo3_r;
  assign dn_t_hi  = thi3_r;
  assign dn_t_lo  = tlo3_r;

endmodule

[rtl/hsv2rgb_back.sv]
module hsv2rgb_back #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  hsv2rgb_pkg::pix_ctl_t  up_ctl,
  input  logic [2*FRAC_BITS+9:0] up_p,
  input  logic [2*FRAC_BITS+9:0] up_q_hi,
  input  logic [2*FRAC_BITS+9:0] up_q_lo,
  input  logic [2*FRAC_BITS+9:0] up_t_hi,
  input  logic [2*FRAC_BITS+9:0] up_t_lo,
  hsv2rgb_rgb_if.source          out_px
);
  import hsv2rgb_pkg::*;

  localparam int PROD_W = 2 * FRAC_BITS + 10;
  localparam int SUM_W  = PROD_W + FRAC_BITS;

  logic [SUM_W-1:0]  q_sum;
  logic [SUM_W-1:0]  t_sum;
  logic [CHAN_W-1:0] cp;
  logic [CHAN_W-1:0] cq;
  logic [CHAN_W-1:0] ct;
  logic [CHAN_W-1:0] red_nxt;
  logic [CHAN_W-1:0] green_nxt;
  logic [CHAN_W-1:0] blue_nxt;
  logic              en;
  logic              acc;

  logic              vld_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;

  // Join the split products and drop the fraction bits
  assign q_sum = (SUM_W'(up_q_hi) << FRAC_BITS) + SUM_W'(up_q_lo);
  assign t_sum = (SUM_W'(up_t_hi) << FRAC_BITS) + SUM_W'(up_t_lo);
  assign cp    = up_p[2*FRAC_BITS +: CHAN_W];
  assign cq    = q_sum[3*FRAC_BITS +: CHAN_W];
  assign ct    = t_sum[3*FRAC_BITS +: CHAN_W];

  // Route channels by hue sector; grey forces all to the value
  always_comb begin
    case (up_ctl.sector)
      SEC_R_TO_Y: begin red_nxt = up_ctl.cv; green_nxt = ct;        blue_nxt = cp;        end
      SEC_Y_TO_G: begin red_nxt = cq;        green_nxt = up_ctl.cv; blue_nxt = cp;        end
      SEC_G_TO_C: begin red_nxt = cp;        green_nxt = up_ctl.cv; blue_nxt = ct;        end
      SEC_C_TO_B: begin red_nxt = cp;        green_nxt = cq;        blue_nxt = up_ctl.cv; end
      SEC_B_TO_M: begin red_nxt = ct;        green_nxt = cp;        blue_nxt = up_ctl.cv; end
      default:    begin red_nxt = up_ctl.cv; green_nxt = cp;        blue_nxt = cq;        end
    endcase
    if (up_ctl.grey) begin
      red_nxt   = up_ctl.cv;
      green_nxt = up_ctl.cv;
      blue_nxt  = up_ctl.cv;
    end
  end

  // Output register: load when empty or when the pixel is taken
  assign en       = !vld_r || out_px.ready;
  assign up_ready = en;
  assign acc      = up_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_px.valid = vld_r;
  assign out_px.red   = red_r;
  assign out_px.green = green_r;
  assign out_px.blue  = blue_r;

`ifndef SYNTHESIS
  // Grey pixels come out with three equal channels
  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    acc && up_ctl.grey |=> red_r == green_r && green_r == blue_r)
    else $error("grey pixel with unequal channels");

  // Every pixel carries the value channel somewhere
  a_value_present: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> red_r == $past(up_ctl.cv) || green_r == $past(up_ctl.cv)
            || blue_r == $past(up_ctl.cv))
    else $error("value channel missing from pixel");

  // Darkened channels never exceed the value channel
  a_p_below_v: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !up_ctl.grey |-> cp <= up_ctl.cv)
    else $error("p channel above value");

  a_qt_below_v: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !up_ctl.grey |-> cq <= up_ctl.cv && ct <= up_ctl.cv)
    else $error("q or t channel above value");
`endif

endmodule

[rtl/hsv_to_rgb888_converter.sv]
// Channel   Modport  Payload                                 Handshake
// in_px     sink     hue, saturation, brightness (16b each)  valid / ready
// out_px    source   red, green, blue (8b each)              valid / ready
//
// Takes one pixel per clock while out_px is not stalled, through four register
// stages: decode/wrap, weight products, channel products, output. out_px.valid
// rises once the pixel has passed through all of them in that order.
// The rate is set by the stage-to-stage handshake; every stage holds one pixel.
// Reset (rst_n low, synchronous) clears the valid bits of all stages.
// A stall on out_px holds the pipeline in place; in_px.ready drops only when
// every stage is full and the output transaction is not taken.
module hsv_to_rgb888_converter #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hsv2rgb_hsv_if.sink   in_px,
  hsv2rgb_rgb_if.source out_px
);
  import hsv2rgb_pkg::*;

  localparam int PROD_W = 2 * FRAC_BITS + 10;

  logic                 f_valid;
  logic                 f_ready;
  pix_ctl_t             f_ctl;
  logic [FRAC_BITS:0]   f_sat;
  logic [FRAC_BITS:0]   f_val;
  logic [FRAC_BITS-1:0] f_frac;

  logic                 m_valid;
  logic                 m_ready;
  pix_ctl_t             m_ctl;
  logic [PROD_W-1:0]    m_p;
  logic [PROD_W-1:0]    m_q_hi;
  logic [PROD_W-1:0]    m_q_lo;
  logic [PROD_W-1:0]    m_t_hi;
  logic [PROD_W-1:0]    m_t_lo;

  // Decode, wrap and value channel
  hsv2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_px),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_ctl   (f_ctl),
    .dn_sat   (f_sat),
    .dn_val   (f_val),
    .dn_frac  (f_frac)
  );

  // Weight and channel products
  hsv2rgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_ctl   (f_ctl),
    .up_sat   (f_sat),
    .up_val   (f_val),
    .up_frac  (f_frac),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .dn_ctl   (m_ctl),
    .dn_p     (m_p),
    .dn_q_hi  (m_q_hi),
    .dn_q_lo  (m_q_lo),
    .dn_t_hi  (m_t_hi),
    .dn_t_lo  (m_t_lo)
  );

  // Truncate, route by sector, output register
  hsv2rgb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (m_valid),
    .up_ready (m_ready),
    .up_ctl   (m_ctl),
    .up_p     (m_p),
    .up_q_hi  (m_q_hi),
    .up_q_lo  (m_q_lo),
    .up_t_hi  (m_t_hi),
    .up_t_lo  (m_t_lo),
    .out_px   (out_px)
  );

`ifndef SYNTHESIS
  // Input backpressure only comes from a full pipeline behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> out_px.valid && !out_px.ready)
    else $error("input stalled without output backpressure");

  // A transaction into an empty pipeline with a free output shows up once it has passed every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_px.valid && in_px.ready && out_px.ready ##1 out_px.ready ##1 out_px.ready
    ##1 out_px.ready |=> out_px.valid)
    else $error("pixel lost in pipeline");
`endif

endmodule
